// ===== hw/rtl/ipv4_header_checker_defines.svh =====
// Assertion macros shared by the IPv4 header checker RTL.
// No dependencies; included by the modules that carry checks.
`ifndef IPV4_HEADER_CHECKER_DEFINES_SVH
`define IPV4_HEADER_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define IHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipv4_header_checker: assertion failed");
// next-cycle implication, disabled while in reset
`define IHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipv4_header_checker: assertion failed");
`else
`define IHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define IHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/ihc_pkg.sv =====
// Shared types and constants for the IPv4 header checker.
// No dependencies; used by ihc_parser, ihc_queue, ihc_emit and the top level.
package ihc_pkg;

    // verdict codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_NOT_V4    = 3'd2;
    localparam logic [2:0] ST_BAD_HLEN  = 3'd3;
    localparam logic [2:0] ST_BAD_TLEN  = 3'd4;
    localparam logic [2:0] ST_FRAGMENT  = 3'd5;
    localparam logic [2:0] ST_ZERO_DST  = 3'd6;
    localparam logic [2:0] ST_UNK_PROTO = 3'd7;

    // protocol classes
    localparam logic [1:0] PK_INVALID = 2'd0;
    localparam logic [1:0] PK_ICMP    = 2'd1;
    localparam logic [1:0] PK_TCP     = 2'd2;
    localparam logic [1:0] PK_UDP     = 2'd3;

    // IP protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'h01;
    localparam logic [7:0] PROTO_TCP  = 8'h06;
    localparam logic [7:0] PROTO_UDP  = 8'h11;

    localparam logic [3:0] IP_VERSION4 = 4'h4;
    localparam logic [5:0] MIN_HDR_LEN = 6'd20;
    localparam logic [7:0] FLAGS_MASK  = 8'hBF;  // all flag/offset bits except DF

    // verdict record handed from the parser to the output stage
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  hdr_len;
        logic [15:0] total_len;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
    } verdict_t;

endpackage

// ===== hw/rtl/ihc_parser.sv =====
// Front end: walks the header bytes and produces one verdict per datagram.
// Depends on ihc_pkg and ipv4_header_checker_defines.svh.
`include "ipv4_header_checker_defines.svh"

module ihc_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic              sof,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       frame_length,
    output logic              vrd_valid,
    input  logic              vrd_ready,
    output ihc_pkg::verdict_t vrd
);

    localparam logic [5:0] POS_VER    = 6'd0;
    localparam logic [5:0] POS_TLEN_H = 6'd2;
    localparam logic [5:0] POS_TLEN_L = 6'd3;
    localparam logic [5:0] POS_FLAGS  = 6'd6;
    localparam logic [5:0] POS_FOFF   = 6'd7;
    localparam logic [5:0] POS_PROTO  = 6'd9;
    localparam logic [5:0] POS_SRC0   = 6'd12;
    localparam logic [5:0] POS_SRC3   = 6'd15;
    localparam logic [5:0] POS_DST0   = 6'd16;
    localparam logic [5:0] POS_DST3   = 6'd19;
    localparam logic [5:0] POS_MAX    = 6'd59;

    logic        done_reg, done_next;
    logic [5:0]  pos_reg, pos_next;
    logic [15:0] fl_reg, fl_next;
    logic [5:0]  hl_reg, hl_next;
    logic [15:0] tl_reg, tl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    logic        accept, active, hit;
    logic [2:0]  status;
    logic [5:0]  cur_pos;

    assign byte_ready = vrd_ready;
    assign accept     = byte_valid && byte_ready;
    assign active     = accept && (sof || !done_reg);

    always_comb begin
        cur_pos    = sof ? 6'd0 : pos_reg;
        fl_next    = sof ? frame_length : fl_reg;
        hl_next    = sof ? 6'd0 : hl_reg;
        tl_next    = sof ? 16'd0 : tl_reg;
        proto_next = sof ? 8'd0 : proto_reg;
        src_next   = sof ? 32'd0 : src_reg;
        dst_next   = sof ? 32'd0 : dst_reg;
        hit        = 1'b0;
        status     = ihc_pkg::ST_OK;

        case (cur_pos)
            POS_VER: begin
                hl_next = {data_byte[3:0], 2'b00};
                if (fl_next < 16'd20) begin
                    hit    = 1'b1;
                    status = ihc_pkg::ST_SHORT;
                end else if (data_byte[7:4] != ihc_pkg::IP_VERSION4) begin
                    hit    = 1'b1;
                    status = ihc_pkg::ST_NOT_V4;
                end else if (hl_next < ihc_pkg::MIN_HDR_LEN ||
                             {10'd0, hl_next} > fl_next) begin
                    hit    = 1'b1;
                    status = ihc_pkg::ST_BAD_HLEN;
                end
            end
            POS_TLEN_H: tl_next = {data_byte, 8'd0};
            POS_TLEN_L: begin
                tl_next = {tl_next[15:8], data_byte};
                if (tl_next < {10'd0, hl_next} || tl_next > fl_next) begin
                    hit    = 1'b1;
                    status = ihc_pkg::ST_BAD_TLEN;
                end
            end
            POS_FLAGS: begin
                if ((data_byte & ihc_pkg::FLAGS_MASK) != 8'd0) begin
                    hit    = 1'b1;
                    status = ihc_pkg::ST_FRAGMENT;
                end
            end
            POS_FOFF: begin
                if (data_byte != 8'd0) begin
                    hit    = 1'b1;
                    status = ihc_pkg::ST_FRAGMENT;
                end
            end
            POS_PROTO: proto_next = data_byte;
            default: ;
        endcase

        if (cur_pos >= POS_SRC0 && cur_pos <= POS_SRC3) begin
            src_next = {src_next[23:0], data_byte};
        end
        if (cur_pos >= POS_DST0 && cur_pos <= POS_DST3) begin
            dst_next = {dst_next[23:0], data_byte};
        end

        if (!hit && cur_pos == POS_DST3 && dst_next == 32'd0) begin
            hit    = 1'b1;
            status = ihc_pkg::ST_ZERO_DST;
        end else if (!hit && cur_pos >= POS_DST3 &&
                     ({1'b0, cur_pos} + 7'd1) >= {1'b0, hl_next}) begin
            hit = 1'b1;
            if (proto_next == ihc_pkg::PROTO_ICMP || proto_next == ihc_pkg::PROTO_TCP ||
                proto_next == ihc_pkg::PROTO_UDP) begin
                status = ihc_pkg::ST_OK;
            end else begin
                status = ihc_pkg::ST_UNK_PROTO;
            end
        end

        pos_next  = hit ? cur_pos : cur_pos + 6'd1;
        done_next = hit;
    end

    assign vrd_valid     = active && hit;
    assign vrd.status    = status;
    assign vrd.hdr_len   = hl_next;
    assign vrd.total_len = tl_next;
    assign vrd.proto     = proto_next;
    assign vrd.src       = src_next;
    assign vrd.dst       = dst_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b1;
            pos_reg  <= 6'd0;
        end else if (active) begin
            done_reg <= done_next;
            pos_reg  <= pos_next;
        end
    end

    // header fields: no reset, cleared (frame length reloaded) on every start of frame
    always_ff @(posedge aclk) begin
        if (active) begin
            fl_reg    <= fl_next;
            hl_reg    <= hl_next;
            tl_reg    <= tl_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

    `IHC_ASSERT_NEXT(a_done_after_verdict, aclk, aresetn, vrd_valid && vrd_ready, done_reg)
    `IHC_ASSERT_NOW(a_pos_in_header, aclk, aresetn, !done_reg, pos_reg <= POS_MAX)

endmodule

// ===== hw/rtl/ihc_queue.sv =====
// Small verdict queue between the parser and the output stage.
// Depends on ihc_pkg and ipv4_header_checker_defines.svh.
`include "ipv4_header_checker_defines.svh"

module ihc_queue #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ihc_pkg::verdict_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ihc_pkg::verdict_t out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ihc_pkg::verdict_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    `IHC_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    `IHC_ASSERT_NEXT(a_count_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CW'(1))

endmodule

// ===== hw/rtl/ihc_emit.sv =====
// Back end: turns a queued verdict into result fields and holds the output register.
// Depends on ihc_pkg.
module ihc_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              vrd_valid,
    output logic              vrd_ready,
    input  ihc_pkg::verdict_t vrd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [1:0]        protocol_kind,
    output logic [5:0]        header_bytes,
    output logic [15:0]       payload_bytes,
    output logic [31:0]       source_address,
    output logic [31:0]       destination_address,
    output logic              learn_source
);

    logic        valid_reg;
    logic [2:0]  status_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [5:0]  hdr_reg;
    logic [15:0] pay_reg;
    logic [31:0] src_reg, dst_reg;
    logic        learn_reg;
    logic        accepted, have_addr, load;

    assign load      = vrd_valid && (!valid_reg || out_ready);
    assign vrd_ready = !valid_reg || out_ready;

    always_comb begin
        accepted  = (vrd.status == ihc_pkg::ST_OK) || (vrd.status == ihc_pkg::ST_UNK_PROTO);
        have_addr = accepted || (vrd.status == ihc_pkg::ST_ZERO_DST);
        kind_next = ihc_pkg::PK_INVALID;
        if (vrd.status == ihc_pkg::ST_OK) begin
            if (vrd.proto == ihc_pkg::PROTO_ICMP) begin
                kind_next = ihc_pkg::PK_ICMP;
            end else if (vrd.proto == ihc_pkg::PROTO_TCP) begin
                kind_next = ihc_pkg::PK_TCP;
            end else begin
                kind_next = ihc_pkg::PK_UDP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= vrd.status;
            kind_reg   <= kind_next;
            hdr_reg    <= accepted ? vrd.hdr_len : 6'd0;
            pay_reg    <= accepted ? (vrd.total_len - {10'd0, vrd.hdr_len}) : 16'd0;
            src_reg    <= have_addr ? vrd.src : 32'd0;
            dst_reg    <= have_addr ? vrd.dst : 32'd0;
            learn_reg  <= accepted;
        end
    end

    assign out_valid           = valid_reg;
    assign status              = status_reg;
    assign protocol_kind       = kind_reg;
    assign header_bytes        = hdr_reg;
    assign payload_bytes       = pay_reg;
    assign source_address      = src_reg;
    assign destination_address = dst_reg;
    assign learn_source        = learn_reg;

endmodule

// ===== hw/rtl/ipv4_header_checker.sv =====
// IPv4 header checker, top level: byte stream in, one verdict per datagram out.
// Depends on ihc_pkg, ihc_parser, ihc_queue and ihc_emit.
// Usage:
//  - s_ channel: one datagram byte per request. s_tuser marks the first byte of a
//    datagram and restarts parsing; s_tdata carries the byte and the frame
//    length, which is sampled only with the first byte.
//  - m_ channel: one verdict per datagram, issued at the first failed check or
//    at the last header byte. Bytes after the verdict, and bytes seen before
//    any start of frame, produce nothing. A new start of frame before the
//    verdict drops the current datagram silently.
//  - Throughput: one byte per cycle, sustained. The parser touches each byte
//    once (compare and capture), so s_tready only drops when the verdict queue
//    is full.
//  - Output path: the verdict is written into the queue when the deciding byte
//    is accepted, then loaded from the queue into the output register, which
//    drives m_tvalid and holds the result until it is taken.
//  - Stall: a held m_tready leaves the verdict in the output register; up to
//    QUEUE_DEPTH more verdicts wait in the queue before s_tready goes low.
//  - Reset (aresetn low, synchronous): queue and output emptied, parser idle
//    until the next start of frame.
module ipv4_header_checker #(
    parameter int QUEUE_DEPTH = 2     // verdict queue entries, 2 or more
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // [7:0] data_byte, [23:8] frame_length
    input  logic        s_tuser,      // [0] start_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [4:3] protocol_kind, [10:5] header_bytes,
    // [26:11] payload_bytes, [58:27] source_address,
    // [90:59] destination_address, [95:91] zero
    output logic [95:0] m_tdata,
    output logic        m_tuser       // [0] learn_source
);

    ihc_pkg::verdict_t front_vrd, back_vrd;
    logic front_valid, front_ready;
    logic back_valid, back_ready;

    logic [2:0]  status;
    logic [1:0]  protocol_kind;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic        learn_source;

    // front: per-byte header checks
    ihc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_valid   (s_tvalid),
        .byte_ready   (s_tready),
        .sof          (s_tuser),
        .data_byte    (s_tdata[7:0]),
        .frame_length (s_tdata[23:8]),
        .vrd_valid    (front_valid),
        .vrd_ready    (front_ready),
        .vrd          (front_vrd)
    );

    // decouples the parser from output back-pressure
    ihc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_vrd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_vrd)
    );

    // back: field formatting and output register
    ihc_emit u_emit (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .vrd_valid           (back_valid),
        .vrd_ready           (back_ready),
        .vrd                 (back_vrd),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .status              (status),
        .protocol_kind       (protocol_kind),
        .header_bytes        (header_bytes),
        .payload_bytes       (payload_bytes),
        .source_address      (source_address),
        .destination_address (destination_address),
        .learn_source        (learn_source)
    );

    assign m_tdata = {5'd0, destination_address, source_address, payload_bytes,
                      header_bytes, protocol_kind, status};
    assign m_tuser = learn_source;

endmodule
